// ----- src/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// Periodic timer table package
// Shared constants and types for the periodic timer table block.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int TableDepth = 64;
	localparam int PeriodBits = 16;
	localparam int IdBits = 16;
	localparam int CmdBits = 2;
	localparam int StatusBits = 3;
	localparam int FieldIdBits = 16;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_FIRED    = 3'd0,
		ST_NONE     = 3'd1,
		ST_ADDED    = 3'd2,
		ST_REARMED  = 3'd3,
		ST_REMOVED  = 3'd4,
		ST_NOTFOUND = 3'd5,
		ST_FULL     = 3'd6,
		ST_IGNORED  = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_RESULT,
		BK_SHIFT,
		BK_TICK,
		BK_TICK_END
	} back_state_t;

endpackage

// ----- src/periodic_timer_table_core.sv -----
// ----------------------------------------------------------------------------
// Periodic timer table core
// A compacted table of periodic timers with add, remove and tick requests.
// ----------------------------------------------------------------------------
// Requests are carried out one at a time. Add and remove search the table one
// entry per cycle, and remove then shifts the later entries down one per
// cycle. A tick walks every used entry through the table memory, one entry
// per cycle while the output is not stalled; the last fired entry is held
// back so it can carry the last flag. Each result appears in the output
// register the cycle after it is formed. A two-entry request queue lets
// requests arrive while the back end works.
module periodic_timer_table_core #(
	parameter int TABLE_DEPTH = ptt_pkg::TableDepth,
	parameter int ID_BITS = ptt_pkg::IdBits,
	parameter int PERIOD_BITS = ptt_pkg::PeriodBits
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             command,
	input  logic [ID_BITS-1:0]     func_id,
	input  logic [PERIOD_BITS-1:0] period,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [2:0]             status,
	output logic [15:0]            fired_id,
	output logic                   last
);

	logic                   q_valid, q_pop, q_ignore;
	ptt_pkg::cmd_t          q_cmd;
	logic [ID_BITS-1:0]     q_id;
	logic [PERIOD_BITS-1:0] q_period;

	ptt_front #(.ID_BITS(ID_BITS), .PERIOD_BITS(PERIOD_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.in_command(command), .in_id(func_id), .in_period(period),
		.q_valid, .q_pop, .q_cmd, .q_ignore, .q_id, .q_period
	);

	ptt_back #(.TABLE_DEPTH(TABLE_DEPTH), .ID_BITS(ID_BITS),
		.PERIOD_BITS(PERIOD_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_cmd, .q_ignore, .q_id, .q_period,
		.out_valid, .out_stall, .status, .fired_id, .last
	);

endmodule

// ----- src/ptt_front.sv -----
// ----------------------------------------------------------------------------
// Periodic timer table front end
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ptt_front #(
	parameter int ID_BITS = ptt_pkg::IdBits,
	parameter int PERIOD_BITS = ptt_pkg::PeriodBits
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             in_command,
	input  logic [ID_BITS-1:0]     in_id,
	input  logic [PERIOD_BITS-1:0] in_period,
	output logic                   q_valid,
	input  logic                   q_pop,
	output ptt_pkg::cmd_t          q_cmd,
	output logic                   q_ignore,
	output logic [ID_BITS-1:0]     q_id,
	output logic [PERIOD_BITS-1:0] q_period
);

	// Two-entry queue.
	logic [1:0]             vld_q;
	logic                   rd_q;
	logic                   wr_q;
	ptt_pkg::cmd_t          cmd_q [2];
	logic                   ign_q [2];
	logic [ID_BITS-1:0]     id_q  [2];
	logic [PERIOD_BITS-1:0] per_q [2];
	logic                   push;
	logic                   ign_in;
	ptt_pkg::cmd_t          cmd_in;

	assign cmd_in = ptt_pkg::cmd_t'(in_command);
	always_comb begin
		case (cmd_in)
			ptt_pkg::CMD_TICK:   ign_in = 1'b0;
			ptt_pkg::CMD_ADD:    ign_in = (in_id == '0) || (in_period == '0);
			ptt_pkg::CMD_REMOVE: ign_in = (in_id == '0);
			default:             ign_in = 1'b1;
		endcase
	end

	assign in_stall = vld_q[wr_q];
	assign push = in_valid && !in_stall;
	assign q_valid = vld_q[rd_q];
	assign q_cmd = cmd_q[rd_q];
	assign q_ignore = ign_q[rd_q];
	assign q_id = id_q[rd_q];
	assign q_period = per_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) begin
				vld_q[wr_q] <= 1'b1;
				wr_q <= !wr_q;
			end
			if (q_pop && q_valid) begin
				vld_q[rd_q] <= 1'b0;
				rd_q <= !rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_q] <= cmd_in;
			ign_q[wr_q] <= ign_in;
			id_q[wr_q] <= in_id;
			per_q[wr_q] <= in_period;
		end
	end

endmodule

// ----- src/ptt_back.sv -----
// ----------------------------------------------------------------------------
// Periodic timer table back end
// Holds the table in a memory and carries out tick, add and remove requests
// one entry per cycle, unless a tick waits on a stalled output.
// ----------------------------------------------------------------------------
module ptt_back #(
	parameter int TABLE_DEPTH = ptt_pkg::TableDepth,
	parameter int ID_BITS = ptt_pkg::IdBits,
	parameter int PERIOD_BITS = ptt_pkg::PeriodBits
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  ptt_pkg::cmd_t                 q_cmd,
	input  logic                          q_ignore,
	input  logic [ID_BITS-1:0]            q_id,
	input  logic [PERIOD_BITS-1:0]        q_period,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic [ptt_pkg::FieldIdBits-1:0] fired_id,
	output logic                          last
);

	localparam int IdxBits = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CntBits = $clog2(TABLE_DEPTH + 1);
	localparam int EntBits = ID_BITS + 2 * PERIOD_BITS;

	// Each memory word: {id, remaining, reload}.
	logic [EntBits-1:0] mem [TABLE_DEPTH];

	ptt_pkg::back_state_t   state_q, state_d;
	logic [CntBits-1:0]     used_q;
	logic [CntBits-1:0]     idx_q;
	logic                   rd_vld_s1;
	logic [IdxBits-1:0]     rd_idx_s1;
	logic [EntBits-1:0]     rd_data_s1;
	ptt_pkg::cmd_t          cmd_q;
	logic                   ign_q;
	logic [ID_BITS-1:0]     id_q;
	logic [PERIOD_BITS-1:0] per_q;
	logic                   found_q;
	logic                   hold_v_q;
	logic [ID_BITS-1:0]     hold_id_q;
	logic                   ov_q;
	ptt_pkg::status_t       ost_q;
	logic [ID_BITS-1:0]     oid_q;
	logic                   olast_q;

	logic                   out_free;
	logic                   at_end;
	logic                   hit;
	logic                   fire;
	logic                   adv;
	logic                   rd_en;
	logic [IdxBits-1:0]     rd_addr;
	logic                   wr_en;
	logic [IdxBits-1:0]     wr_addr;
	logic [EntBits-1:0]     wr_data;
	logic                   emit;
	ptt_pkg::status_t       emit_st;
	logic [ID_BITS-1:0]     emit_id;
	logic                   emit_last;
	ptt_pkg::status_t       res_st;
	logic [ID_BITS-1:0]     e_id;
	logic [PERIOD_BITS-1:0] e_rem, e_rel, dec;

	assign out_free = !ov_q || !out_stall;
	assign e_id = rd_data_s1[EntBits-1 -: ID_BITS];
	assign e_rem = rd_data_s1[2*PERIOD_BITS-1 -: PERIOD_BITS];
	assign e_rel = rd_data_s1[PERIOD_BITS-1:0];
	assign dec = e_rem - PERIOD_BITS'(1);
	assign at_end = (idx_q == used_q);
	assign hit = rd_vld_s1 && (e_id == id_q);
	assign fire = rd_vld_s1 && (dec == '0);
	// The last fired entry of a tick is held back so that it can be flagged
	// last; a new fire pushes the held one out, and only that waits on the
	// output register.
	assign adv = !(fire && hold_v_q) || out_free;

	// Result code for a finished non-tick request.
	always_comb begin
		res_st = ptt_pkg::ST_IGNORED;
		if (!ign_q) begin
			case (cmd_q)
				ptt_pkg::CMD_ADD:
					if (found_q) res_st = ptt_pkg::ST_REARMED;
					else if (used_q < CntBits'(TABLE_DEPTH)) res_st = ptt_pkg::ST_ADDED;
					else res_st = ptt_pkg::ST_FULL;
				ptt_pkg::CMD_REMOVE:
					res_st = found_q ? ptt_pkg::ST_REMOVED : ptt_pkg::ST_NOTFOUND;
				default: res_st = ptt_pkg::ST_IGNORED;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ptt_pkg::BK_IDLE:
				if (q_valid) begin
					if (q_cmd == ptt_pkg::CMD_TICK) state_d = ptt_pkg::BK_TICK;
					else if (q_ignore) state_d = ptt_pkg::BK_RESULT;
					else state_d = ptt_pkg::BK_SCAN;
				end
			ptt_pkg::BK_SCAN:
				if (hit) state_d = (cmd_q == ptt_pkg::CMD_REMOVE) ?
					ptt_pkg::BK_SHIFT : ptt_pkg::BK_RESULT;
				else if (at_end) state_d = ptt_pkg::BK_RESULT;
			ptt_pkg::BK_SHIFT:
				if (at_end) state_d = ptt_pkg::BK_RESULT;
			ptt_pkg::BK_RESULT:
				if (out_free) state_d = ptt_pkg::BK_IDLE;
			ptt_pkg::BK_TICK:
				if (at_end && adv) state_d = ptt_pkg::BK_TICK_END;
			ptt_pkg::BK_TICK_END:
				if (out_free) state_d = ptt_pkg::BK_IDLE;
			default: state_d = ptt_pkg::BK_IDLE;
		endcase
	end

	// Memory access and result control.
	always_comb begin
		q_pop = (state_q == ptt_pkg::BK_IDLE);
		rd_en = 1'b0;
		rd_addr = idx_q[IdxBits-1:0];
		wr_en = 1'b0;
		wr_addr = rd_idx_s1;
		wr_data = rd_data_s1;
		emit = 1'b0;
		emit_st = ptt_pkg::ST_NONE;
		emit_id = '0;
		emit_last = 1'b1;
		case (state_q)
			ptt_pkg::BK_SCAN: begin
				rd_en = !at_end && !hit;
				if (hit && cmd_q == ptt_pkg::CMD_ADD) begin
					wr_en = 1'b1;
					wr_data = {e_id, per_q, per_q};
				end
			end
			ptt_pkg::BK_SHIFT: begin
				rd_en = !at_end;
				if (rd_vld_s1) begin
					wr_en = 1'b1;
					wr_addr = rd_idx_s1 - IdxBits'(1);
				end
			end
			ptt_pkg::BK_RESULT: begin
				emit = out_free;
				emit_st = res_st;
				emit_id = id_q;
				if (out_free && res_st == ptt_pkg::ST_ADDED) begin
					wr_en = 1'b1;
					wr_addr = used_q[IdxBits-1:0];
					wr_data = {id_q, per_q, per_q};
				end
			end
			ptt_pkg::BK_TICK: begin
				rd_en = adv && !at_end;
				wr_en = adv && rd_vld_s1;
				wr_data = {e_id, fire ? e_rel : dec, e_rel};
				emit = fire && hold_v_q && out_free;
				emit_st = ptt_pkg::ST_FIRED;
				emit_id = hold_id_q;
				emit_last = 1'b0;
			end
			ptt_pkg::BK_TICK_END: begin
				emit = out_free;
				emit_st = hold_v_q ? ptt_pkg::ST_FIRED : ptt_pkg::ST_NONE;
				emit_id = hold_v_q ? hold_id_q : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_idx_s1 <= rd_addr;
		end
		if (q_pop && q_valid) begin
			cmd_q <= q_cmd;
			ign_q <= q_ignore;
			id_q <= q_id;
			per_q <= q_period;
		end
		if (emit) begin
			ost_q <= emit_st;
			oid_q <= emit_id;
			olast_q <= emit_last;
		end
		if (state_q == ptt_pkg::BK_TICK && adv && fire) hold_id_q <= e_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::BK_IDLE;
			used_q <= '0;
			idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			hold_v_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			if (state_q != ptt_pkg::BK_TICK || adv) rd_vld_s1 <= rd_en;
			if (state_q == ptt_pkg::BK_IDLE) begin
				idx_q <= '0;
				found_q <= 1'b0;
				hold_v_q <= 1'b0;
			end else begin
				if (rd_en) idx_q <= idx_q + CntBits'(1);
				if (state_q == ptt_pkg::BK_SCAN && hit) found_q <= 1'b1;
				if (state_q == ptt_pkg::BK_TICK && adv && fire) hold_v_q <= 1'b1;
			end
			if (state_q == ptt_pkg::BK_RESULT && out_free) begin
				if (res_st == ptt_pkg::ST_ADDED) used_q <= used_q + CntBits'(1);
				else if (res_st == ptt_pkg::ST_REMOVED) used_q <= used_q - CntBits'(1);
			end
		end
	end

	assign out_valid = ov_q;
	assign status = ost_q;
	assign fired_id = ptt_pkg::FieldIdBits'(oid_q);
	assign last = olast_q;

endmodule
